FILE: hdl/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg
// Shared widths, register indexes, reset values and state encoding for the
// greedy distance suppression unit.
// ----------------------------------------------------------------------------
package gds_pkg;

  // Default sizing of the kept-point chain
  localparam int MaxKeptDef   = 16;
  localparam int CoordBitsDef = 12;
  localparam int CoordMaxW    = 16;

  // Field widths
  localparam int InCoordW = 12;
  localparam int AngleW   = 11;
  localparam int TotalW   = 7;
  localparam int HeightW  = 12;
  localparam int WidthW   = 12;
  localparam int MarginW  = 11;
  localparam int DistW    = 12;
  localparam int LimitW   = 7;
  localparam int LimSqW   = 2 * DistW;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  // Register reset values
  localparam logic [HeightW-1:0] HeightRst = HeightW'(480);
  localparam logic [WidthW-1:0]  WidthRst  = WidthW'(640);
  localparam logic [MarginW-1:0] MarginRst = '0;
  localparam logic [DistW-1:0]   DistRst   = DistW'(25);
  localparam logic [LimitW-1:0]  LimitRst  = LimitW'(16);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEIGHT,
    CFG_WIDTH,
    CFG_MARGIN,
    CFG_MIN_DIST,
    CFG_KEEP_LIMIT
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DECIDE
  } state_e;

endpackage

FILE: hdl/gds_cand_if.sv
// ----------------------------------------------------------------------------
// gds_cand_if
// Candidate channel: valid/ready handshake with one point candidate.
// ----------------------------------------------------------------------------
interface gds_cand_if;
  logic                         valid;
  logic                         ready;
  logic                         start_list;
  logic [gds_pkg::InCoordW-1:0] cand_x;
  logic [gds_pkg::InCoordW-1:0] cand_y;
  logic [gds_pkg::AngleW-1:0]   cand_angle;

  modport source (output valid, start_list, cand_x, cand_y, cand_angle, input ready);
  modport sink   (input valid, start_list, cand_x, cand_y, cand_angle, output ready);
endinterface

FILE: hdl/gds_res_if.sv
// ----------------------------------------------------------------------------
// gds_res_if
// Result channel: valid/ready handshake with one suppression decision.
// ----------------------------------------------------------------------------
interface gds_res_if;
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic [gds_pkg::TotalW-1:0] kept_total;
  logic                       list_full;
  logic [gds_pkg::AngleW-1:0] out_angle;

  modport source (output valid, accepted, kept_total, list_full, out_angle, input ready);
  modport sink   (input valid, accepted, kept_total, list_full, out_angle, output ready);
endinterface

FILE: hdl/gds_cell.sv
// ----------------------------------------------------------------------------
// gds_cell
// One slot of the kept-point chain: holds a point, squares its distance to
// the current candidate and flags it when the candidate comes too close.
// ----------------------------------------------------------------------------
module gds_cell #(
  parameter int CoordBits = gds_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         shift_i,
  input  logic                         active_i,
  input  logic [CoordBits-1:0]         cand_col_i,
  input  logic [CoordBits-1:0]         cand_row_i,
  input  logic [CoordBits-1:0]         prev_col_i,
  input  logic [CoordBits-1:0]         prev_row_i,
  input  logic [gds_pkg::LimSqW-1:0]   lim_i,
  output logic [CoordBits-1:0]         col_o,
  output logic [CoordBits-1:0]         row_o,
  output logic                         near_o
);

  localparam int SqW  = 2 * CoordBits;
  localparam int SumW = SqW + 1;
  localparam int CmpW = (SumW > gds_pkg::LimSqW) ? SumW : gds_pkg::LimSqW;

  logic [CoordBits-1:0] col_q, row_q;
  logic [CoordBits-1:0] adx, ady;
  logic [SqW-1:0]       dx2_d, dy2_d, dx2_q, dy2_q;
  logic [SumW-1:0]      dist2;

  // Take the point of the neighbor when the chain advances
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= prev_col_i;
      row_q <= prev_row_i;
    end
  end

  // Absolute offsets and their squares
  always_comb begin
    adx   = (cand_col_i >= col_q) ? (cand_col_i - col_q) : (col_q - cand_col_i);
    ady   = (cand_row_i >= row_q) ? (cand_row_i - row_q) : (row_q - cand_row_i);
    dx2_d = SqW'(adx) * SqW'(adx);
    dy2_d = SqW'(ady) * SqW'(ady);
  end

  always_ff @(posedge clk_i) begin
    dx2_q <= dx2_d;
    dy2_q <= dy2_d;
  end

  // Compare the squared distance against the squared minimum distance
  assign dist2  = SumW'(dx2_q) + SumW'(dy2_q);
  assign near_o = active_i && (CmpW'(dist2) < CmpW'(lim_i));

  assign col_o = col_q;
  assign row_o = row_q;

endmodule

FILE: hdl/greedy_distance_suppression_unit.sv
// ----------------------------------------------------------------------------
// greedy_distance_suppression_unit
// Greedy point suppression over a chain of kept-point cells.
// ----------------------------------------------------------------------------
// Candidates come in best-first. Each one is kept when it lies strictly
// inside the image less the border margin, is at least min_distance away
// from every kept point and the list still has room under keep_limit
// (saturated at MaxKept). Every candidate gives exactly one result with the
// accepted flag, the kept total, the full flag and the echoed angle;
// start_list empties the list first. From acceptance to result a candidate
// passes ST_SQUARE, in which every cell squares its offsets in parallel,
// and then ST_DECIDE, which adds, compares and combines the cell flags. The
// input is ready again in the cycle after the result is loaded, so a new
// candidate cannot enter before the last one has been decided. The result
// register lets the next candidate enter while a result still waits; a
// stalled result holds the unit in its decision cycle.
// Configuration is taken at any time but must be written only while idle.
// ----------------------------------------------------------------------------
module greedy_distance_suppression_unit #(
  parameter int MaxKept   = gds_pkg::MaxKeptDef,
  parameter int CoordBits = gds_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gds_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gds_pkg::CfgDataW-1:0]  cfg_wdata_i,
  gds_cand_if.sink                      cand_i,
  gds_res_if.source                     res_o
);

  localparam int CntW = $clog2(MaxKept + 1);
  localparam int BrdW = gds_pkg::CoordMaxW + 2;

  // Configuration registers
  logic [gds_pkg::HeightW-1:0] height_q;
  logic [gds_pkg::WidthW-1:0]  width_q;
  logic [gds_pkg::MarginW-1:0] margin_q;
  logic [gds_pkg::DistW-1:0]   dist_q;
  logic [gds_pkg::LimitW-1:0]  limit_q;
  logic [gds_pkg::LimSqW-1:0]  lim_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= gds_pkg::HeightRst;
      width_q  <= gds_pkg::WidthRst;
      margin_q <= gds_pkg::MarginRst;
      dist_q   <= gds_pkg::DistRst;
      limit_q  <= gds_pkg::LimitRst;
    end else if (cfg_we_i) begin
      unique case (gds_pkg::cfg_idx_e'(cfg_idx_i))
        gds_pkg::CFG_HEIGHT:     height_q <= cfg_wdata_i[gds_pkg::HeightW-1:0];
        gds_pkg::CFG_WIDTH:      width_q  <= cfg_wdata_i[gds_pkg::WidthW-1:0];
        gds_pkg::CFG_MARGIN:     margin_q <= cfg_wdata_i[gds_pkg::MarginW-1:0];
        gds_pkg::CFG_MIN_DIST:   dist_q   <= cfg_wdata_i[gds_pkg::DistW-1:0];
        gds_pkg::CFG_KEEP_LIMIT: limit_q  <= cfg_wdata_i[gds_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Squared minimum distance, kept current from the register
  always_ff @(posedge clk_i) begin
    lim_sq_q <= gds_pkg::LimSqW'(dist_q) * gds_pkg::LimSqW'(dist_q);
  end

  // Control and candidate registers
  gds_pkg::state_e          state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [CoordBits-1:0]     cand_x_q, cand_y_q;
  logic [gds_pkg::AngleW-1:0] angle_q;
  logic                     inside_q;
  logic                     res_valid_q, res_valid_d;
  logic                     res_acc_q, res_full_q;
  logic [gds_pkg::TotalW-1:0] res_total_q;
  logic [gds_pkg::AngleW-1:0] res_angle_q;

  logic [gds_pkg::CoordMaxW-1:0] x_wide, y_wide;
  logic                     cand_take, commit, keep, room, inside_d;
  logic [gds_pkg::LimitW-1:0] lim_eff;
  logic [CntW-1:0]          total_new;
  logic [MaxKept-1:0]       near;
  logic signed [BrdW-1:0]   bx, by, bm, bw, bh;

  // Map the input coordinates onto the stored coordinate width
  assign x_wide = gds_pkg::CoordMaxW'(cand_i.cand_x);
  assign y_wide = gds_pkg::CoordMaxW'(cand_i.cand_y);

  assign cand_take = cand_i.valid && cand_i.ready;
  assign cand_i.ready = (state_q == gds_pkg::ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (cand_take) begin
      cand_x_q <= x_wide[CoordBits-1:0];
      cand_y_q <= y_wide[CoordBits-1:0];
      angle_q  <= cand_i.cand_angle;
    end
  end

  // Border test on the latched candidate
  always_comb begin
    bx = $signed(BrdW'(cand_x_q));
    by = $signed(BrdW'(cand_y_q));
    bm = $signed(BrdW'(margin_q));
    bw = $signed(BrdW'(width_q)) - bm;
    bh = $signed(BrdW'(height_q)) - bm;
    inside_d = (bm < bx) && (bx < bw) && (bm < by) && (by < bh);
  end

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
  end

  // Effective limit and room check
  assign lim_eff = (limit_q > gds_pkg::LimitW'(MaxKept)) ? gds_pkg::LimitW'(MaxKept) : limit_q;
  assign room    = gds_pkg::LimitW'(count_q) < lim_eff;

  // Chain of kept-point cells, newest point in the first cell
  logic [CoordBits-1:0] col_chain [MaxKept];
  logic [CoordBits-1:0] row_chain [MaxKept];

  for (genvar j = 0; j < MaxKept; j++) begin : g_cell
    logic [CoordBits-1:0] prev_col, prev_row;
    if (j == 0) begin : g_head
      assign prev_col = cand_x_q;
      assign prev_row = cand_y_q;
    end else begin : g_link
      assign prev_col = col_chain[j-1];
      assign prev_row = row_chain[j-1];
    end

    gds_cell #(
      .CoordBits (CoordBits)
    ) u_cell (
      .clk_i      (clk_i),
      .shift_i    (commit && keep),
      .active_i   (CntW'(j) < count_q),
      .cand_col_i (cand_x_q),
      .cand_row_i (cand_y_q),
      .prev_col_i (prev_col),
      .prev_row_i (prev_row),
      .lim_i      (lim_sq_q),
      .col_o      (col_chain[j]),
      .row_o      (row_chain[j]),
      .near_o     (near[j])
    );
  end

  // Decision
  assign commit    = (state_q == gds_pkg::ST_DECIDE) && (!res_valid_q || res_o.ready);
  assign keep      = room && inside_q && !(|near);
  assign total_new = keep ? (count_q + CntW'(1)) : count_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_valid_d = res_valid_q;
    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end
    unique case (state_q)
      gds_pkg::ST_IDLE: begin
        if (cand_take) begin
          state_d = gds_pkg::ST_SQUARE;
          if (cand_i.start_list) begin
            count_d = '0;
          end
        end
      end
      gds_pkg::ST_SQUARE: begin
        state_d = gds_pkg::ST_DECIDE;
      end
      gds_pkg::ST_DECIDE: begin
        if (commit) begin
          state_d     = gds_pkg::ST_IDLE;
          count_d     = total_new;
          res_valid_d = 1'b1;
        end
      end
      default: state_d = gds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gds_pkg::ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_acc_q   <= keep;
      res_total_q <= gds_pkg::TotalW'(total_new);
      res_full_q  <= gds_pkg::LimitW'(total_new) >= lim_eff;
      res_angle_q <= angle_q;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.accepted   = res_acc_q;
  assign res_o.kept_total = res_total_q;
  assign res_o.list_full  = res_full_q;
  assign res_o.out_angle  = res_angle_q;

endmodule
